>>> src/qspind_pkg.sv
// ----------------------------------------------------------------------------
// Quad SPI nibble decoder package
// Shared constants and types for the decoder core, result buffer and top.
// ----------------------------------------------------------------------------
package qspind_pkg;

   localparam int TIME_BITS_DEF = 48;

   // symbol codes on the result channel
   localparam logic [1:0] KIND_SELECT   = 2'd0;
   localparam logic [1:0] KIND_DATA     = 2'd1;
   localparam logic [1:0] KIND_DESELECT = 2'd2;

   // load request from the core to the result buffer
   typedef struct packed {
      logic load;   // this sample produces at least one result
      logic pair;   // this sample produces two results
   } rsp_ctl_type;

endpackage

>>> src/qspind_if.sv
// ----------------------------------------------------------------------------
// Quad SPI nibble decoder channel interfaces
// Sample channel and symbol channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface qspind_req_if #(
   parameter int TIME_BITS = qspind_pkg::TIME_BITS_DEF
) ();
   logic                 valid;
   logic                 ready;
   logic [TIME_BITS-1:0] sample_time;
   logic                 chip_select_n;
   logic                 clock_level;
   logic [3:0]           dq_nibble;

   modport source (output valid, sample_time, chip_select_n, clock_level, dq_nibble,
                   input ready);
   modport sink (input valid, sample_time, chip_select_n, clock_level, dq_nibble,
                 output ready);
endinterface

interface qspind_rsp_if #(
   parameter int TIME_BITS = qspind_pkg::TIME_BITS_DEF
) ();
   logic                        valid;
   logic                        ready;
   logic [1:0]                  symbol_kind;
   logic [7:0]                  data_byte;
   logic [TIME_BITS-1:0]        start_time;
   logic signed [TIME_BITS-1:0] duration;
   logic                        last_of_run;

   modport source (output valid, symbol_kind, data_byte, start_time, duration,
                   last_of_run, input ready);
   modport sink (input valid, symbol_kind, data_byte, start_time, duration,
                 last_of_run, output ready);
endinterface

>>> src/quad_spi_nibble_decoder.sv
// A sample waits in the sample register until the result buffer can load it.
// Throughput: one sample per cycle while the buffer can load; a sample that yields two
// words (deselect with clock low) holds both result slots until both words are taken.
// Reset: synchronous, active high; returns to waiting for deselect and empties all stages.
// ----------------------------------------------------------------------------
// Quad SPI nibble decoder
// Sample register, decoder core and result buffer for a quad SPI bus stream.
// ----------------------------------------------------------------------------
module quad_spi_nibble_decoder #(
   parameter int TIME_BITS = qspind_pkg::TIME_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   qspind_req_if.sink   req_chan,
   qspind_rsp_if.source rsp_chan
);

   logic                    in_valid_ff;
   logic [TIME_BITS-1:0]    time_ff;
   logic                    cs_n_ff;
   logic                    clk_ff;
   logic [3:0]              dq_ff;
   logic                    can_load;
   logic                    fire;
   logic                    take;
   qspind_pkg::rsp_ctl_type ctl;
   logic [1:0]              r0_kind;
   logic [7:0]              r0_byte;
   logic [TIME_BITS-1:0]    r0_start;
   logic [TIME_BITS-1:0]    r0_len;
   logic [1:0]              r1_kind;
   logic [TIME_BITS-1:0]    r1_start;
   logic [TIME_BITS-1:0]    r1_len;

   assign fire           = in_valid_ff && can_load;
   assign req_chan.ready = !in_valid_ff || can_load;
   assign take           = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take || fire) begin
         in_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         time_ff <= req_chan.sample_time;
         cs_n_ff <= req_chan.chip_select_n;
         clk_ff  <= req_chan.clock_level;
         dq_ff   <= req_chan.dq_nibble;
      end
   end

   qspind_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .sample_time   (time_ff),
      .chip_select_n (cs_n_ff),
      .clock_level   (clk_ff),
      .dq_nibble     (dq_ff),
      .ctl           (ctl),
      .r0_kind       (r0_kind),
      .r0_byte       (r0_byte),
      .r0_start      (r0_start),
      .r0_len        (r0_len),
      .r1_kind       (r1_kind),
      .r1_start      (r1_start),
      .r1_len        (r1_len)
   );

   qspind_out_buf #(
      .TIME_BITS (TIME_BITS)
   ) u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .ctl      (ctl),
      .r0_kind  (r0_kind),
      .r0_byte  (r0_byte),
      .r0_start (r0_start),
      .r0_len   (r0_len),
      .r1_kind  (r1_kind),
      .r1_start (r1_start),
      .r1_len   (r1_len),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> src/qspind_core.sv
// ----------------------------------------------------------------------------
// Quad SPI nibble decoder core
// Bus state, nibble assembly and symbol generation for one sample.
// ----------------------------------------------------------------------------
module qspind_core #(
   parameter int TIME_BITS = qspind_pkg::TIME_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  logic [TIME_BITS-1:0]         sample_time,
   input  logic                         chip_select_n,
   input  logic                         clock_level,
   input  logic [3:0]                   dq_nibble,
   output qspind_pkg::rsp_ctl_type      ctl,
   output logic [1:0]                   r0_kind,
   output logic [7:0]                   r0_byte,
   output logic [TIME_BITS-1:0]         r0_start,
   output logic [TIME_BITS-1:0]         r0_len,
   output logic [1:0]                   r1_kind,
   output logic [TIME_BITS-1:0]         r1_start,
   output logic [TIME_BITS-1:0]         r1_len
);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_DESEL = 2'd1;
   localparam logic [1:0] PH_CLKLO = 2'd2;
   localparam logic [1:0] PH_CLKHI = 2'd3;

   logic [1:0]           phase_ff, phase_in;
   logic                 expect_hi_ff, expect_hi_in;
   logic                 first_ff, first_in;
   logic [7:0]           byte_ff, byte_in;
   logic [TIME_BITS-1:0] sym_start_ff, sym_start_in;
   logic [TIME_BITS-1:0] prev_len_ff, prev_len_in;

   logic [TIME_BITS-1:0] len_now;
   logic [TIME_BITS-1:0] flush_end;

   assign len_now   = sample_time - sym_start_ff;
   assign flush_end = sym_start_ff + prev_len_ff;

   always_comb begin
      phase_in     = phase_ff;
      expect_hi_in = expect_hi_ff;
      first_in     = first_ff;
      byte_in      = byte_ff;
      sym_start_in = sym_start_ff;
      prev_len_in  = prev_len_ff;
      ctl          = '0;
      r0_kind      = qspind_pkg::KIND_DATA;
      r0_byte      = byte_ff;
      r0_start     = sym_start_ff;
      r0_len       = len_now;
      r1_kind      = qspind_pkg::KIND_DESELECT;
      r1_start     = flush_end;
      r1_len       = sample_time - flush_end;
      case (phase_ff)
         PH_IDLE: begin
            if (chip_select_n) begin
               phase_in = PH_DESEL;
            end
         end
         PH_DESEL: begin
            if (!chip_select_n) begin
               phase_in     = PH_CLKLO;
               byte_in      = '0;
               expect_hi_in = 1'b1;
               sym_start_in = sample_time;
               first_in     = 1'b1;
            end
         end
         PH_CLKLO: begin
            if (clock_level) begin
               phase_in     = PH_CLKHI;
               expect_hi_in = !expect_hi_ff;
               if (expect_hi_ff) begin
                  ctl.load = 1'b1;
                  if (first_ff) begin
                     r0_kind = qspind_pkg::KIND_SELECT;
                     r0_byte = '0;
                  end else begin
                     prev_len_in = len_now;
                  end
                  byte_in      = {dq_nibble, 4'h0};
                  sym_start_in = sample_time;
                  first_in     = 1'b0;
               end else begin
                  byte_in = byte_ff | {4'h0, dq_nibble};
               end
            end else if (chip_select_n) begin
               // flush the byte in progress with the last byte's length
               ctl.load     = 1'b1;
               ctl.pair     = 1'b1;
               r0_len       = prev_len_ff;
               sym_start_in = sample_time;
               phase_in     = PH_DESEL;
            end
         end
         default: begin
            if (!clock_level) begin
               phase_in = PH_CLKLO;
            end else if (chip_select_n) begin
               ctl.load     = 1'b1;
               r0_kind      = qspind_pkg::KIND_DESELECT;
               r0_byte      = '0;
               sym_start_in = sample_time;
               phase_in     = PH_DESEL;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         expect_hi_ff <= 1'b1;
         first_ff     <= 1'b0;
         byte_ff      <= '0;
         sym_start_ff <= '0;
         prev_len_ff  <= '0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         expect_hi_ff <= expect_hi_in;
         first_ff     <= first_in;
         byte_ff      <= byte_in;
         sym_start_ff <= sym_start_in;
         prev_len_ff  <= prev_len_in;
      end
   end

endmodule

>>> src/qspind_out_buf.sv
// ----------------------------------------------------------------------------
// Quad SPI nibble decoder result buffer
// Two-slot result register feeding the symbol channel in order.
// ----------------------------------------------------------------------------
module qspind_out_buf #(
   parameter int TIME_BITS = qspind_pkg::TIME_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  qspind_pkg::rsp_ctl_type ctl,
   input  logic [1:0]              r0_kind,
   input  logic [7:0]              r0_byte,
   input  logic [TIME_BITS-1:0]    r0_start,
   input  logic [TIME_BITS-1:0]    r0_len,
   input  logic [1:0]              r1_kind,
   input  logic [TIME_BITS-1:0]    r1_start,
   input  logic [TIME_BITS-1:0]    r1_len,
   output logic                    can_load,
   qspind_rsp_if.source            rsp_chan
);

   logic [1:0]           cnt_ff, cnt_in;
   logic [1:0]           kind0_ff, kind0_in;
   logic [7:0]           byte0_ff, byte0_in;
   logic [TIME_BITS-1:0] start0_ff, start0_in;
   logic [TIME_BITS-1:0] len0_ff, len0_in;
   logic                 last0_ff, last0_in;
   logic [1:0]           kind1_ff;
   logic [TIME_BITS-1:0] start1_ff;
   logic [TIME_BITS-1:0] len1_ff;
   logic                 pop;
   logic                 load;

   assign pop      = rsp_chan.valid && rsp_chan.ready;
   assign can_load = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_chan.ready);
   assign load     = fire && ctl.load;

   always_comb begin
      cnt_in    = cnt_ff;
      kind0_in  = kind0_ff;
      byte0_in  = byte0_ff;
      start0_in = start0_ff;
      len0_in   = len0_ff;
      last0_in  = last0_ff;
      if (load) begin
         cnt_in    = ctl.pair ? 2'd2 : 2'd1;
         kind0_in  = r0_kind;
         byte0_in  = r0_byte;
         start0_in = r0_start;
         len0_in   = r0_len;
         last0_in  = !ctl.pair;
      end else if (pop) begin
         // advance the second word into the head slot
         cnt_in    = cnt_ff - 2'd1;
         kind0_in  = kind1_ff;
         byte0_in  = '0;
         start0_in = start1_ff;
         len0_in   = len1_ff;
         last0_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      kind0_ff  <= kind0_in;
      byte0_ff  <= byte0_in;
      start0_ff <= start0_in;
      len0_ff   <= len0_in;
      last0_ff  <= last0_in;
      if (load) begin
         kind1_ff  <= r1_kind;
         start1_ff <= r1_start;
         len1_ff   <= r1_len;
      end
   end

   assign rsp_chan.valid       = (cnt_ff != 2'd0);
   assign rsp_chan.symbol_kind = kind0_ff;
   assign rsp_chan.data_byte   = byte0_ff;
   assign rsp_chan.start_time  = start0_ff;
   assign rsp_chan.duration    = $signed(len0_ff);
   assign rsp_chan.last_of_run = last0_ff;

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad SPI nibble decoder testbench
// Drives timestamped bus samples as well-formed packets with random content,
// plus noise, and checks every symbol word against an in-bench decoder copy.
// ----------------------------------------------------------------------------

localparam int TW = qspind_pkg::TIME_BITS_DEF;

typedef enum logic [1:0] {
   BUS_UNKNOWN,
   BUS_DESELECTED,
   BUS_CLK_LOW,
   BUS_CLK_HIGH
} bus_phase_type;

typedef struct packed {
   logic [1:0]    kind;
   logic [7:0]    data_byte;
   logic [TW-1:0] start_time;
   logic [TW-1:0] duration;
   logic          last_of_run;
} bus_symbol_type;

class qspi_scoreboard_type;
   bus_phase_type  phase;
   bit             want_high;
   bit             first_rise;
   logic [7:0]     partial;
   logic [TW-1:0]  sym_start;
   logic [TW-1:0]  byte_len;
   bus_symbol_type due_symbols[$];
   int             mismatches;

   function new();
      phase      = BUS_UNKNOWN;
      want_high  = 1'b1;
      first_rise = 1'b0;
      partial    = '0;
      sym_start  = '0;
      byte_len   = '0;
      mismatches = 0;
   endfunction

   function void queue_symbol(logic [1:0] kind, logic [7:0] value, logic [TW-1:0] start,
                              logic [TW-1:0] len);
      bus_symbol_type sym;
      sym.kind        = kind;
      sym.data_byte   = value;
      sym.start_time  = start;
      sym.duration    = len;
      sym.last_of_run = 1'b0;
      due_symbols     = {due_symbols, sym};
   endfunction

   function void note_sample(logic [TW-1:0] t, logic cs_n, logic clk, logic [3:0] dq);
      int held;
      held = due_symbols.size();
      case (phase)
         BUS_UNKNOWN: begin
            if (cs_n) phase = BUS_DESELECTED;
         end
         BUS_DESELECTED: begin
            if (!cs_n) begin
               phase      = BUS_CLK_LOW;
               partial    = '0;
               want_high  = 1'b1;
               sym_start  = t;
               first_rise = 1'b1;
            end
         end
         BUS_CLK_LOW: begin
            if (clk) begin
               phase = BUS_CLK_HIGH;
               if (want_high) begin
                  // a high nibble closes the previous symbol
                  if (first_rise) begin
                     queue_symbol(qspind_pkg::KIND_SELECT, 8'h00, sym_start, t - sym_start);
                  end else begin
                     byte_len = t - sym_start;
                     queue_symbol(qspind_pkg::KIND_DATA, partial, sym_start, byte_len);
                  end
                  partial    = {dq, 4'h0};
                  sym_start  = t;
                  first_rise = 1'b0;
               end else begin
                  partial = partial | {4'h0, dq};
               end
               want_high = !want_high;
            end else if (cs_n) begin
               // flush the byte in progress with the previous byte's length
               queue_symbol(qspind_pkg::KIND_DATA, partial, sym_start, byte_len);
               sym_start = sym_start + byte_len;
               queue_symbol(qspind_pkg::KIND_DESELECT, 8'h00, sym_start, t - sym_start);
               sym_start = t;
               phase     = BUS_DESELECTED;
            end
         end
         BUS_CLK_HIGH: begin
            if (!clk) begin
               phase = BUS_CLK_LOW;
            end else if (cs_n) begin
               queue_symbol(qspind_pkg::KIND_DESELECT, 8'h00, sym_start, t - sym_start);
               sym_start = t;
               phase     = BUS_DESELECTED;
            end
         end
      endcase
      if (due_symbols.size() > held) due_symbols[due_symbols.size() - 1].last_of_run = 1'b1;
   endfunction

   function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   function void check_symbol(bus_symbol_type got);
      bus_symbol_type want;
      if (due_symbols.size() == 0) begin
         $error("symbol word with none outstanding: kind %0d start 0x%0h",
                got.kind, got.start_time);
         mismatches++;
         return;
      end
      want = due_symbols.pop_front();
      compare_field("symbol_kind", 64'(want.kind), 64'(got.kind));
      compare_field("data_byte", 64'(want.data_byte), 64'(got.data_byte));
      compare_field("start_time", 64'(want.start_time), 64'(got.start_time));
      compare_field("duration", 64'(want.duration), 64'(got.duration));
      compare_field("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
   endfunction
endclass

module tb;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE      = 8;
   localparam int ITEM_TARGET = 1650;

   logic clock;
   logic reset;

   qspind_req_if req_chan ();
   qspind_rsp_if rsp_chan ();

   quad_spi_nibble_decoder i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   qspi_scoreboard_type board;

   logic [TW-1:0] now;
   int            burst_left = 0;
   bit            steady_sender = 1'b0;
   int            sent_count = 0;
   int            cycle_count = 0;
   logic [15:0]   stall_mask = '1;
   int            stall_age = 0;
   logic [3:0]    stall_pos = '0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver stall pattern, re-picked at random when its age runs out
   always @(negedge clock) begin
      if (stall_age == 0) begin
         stall_age = $urandom_range(100, 300);
         case ($urandom_range(0, 3))
            0: stall_mask = '1;
            1: stall_mask = 16'h8001;
            default: stall_mask = 16'($urandom) | 16'h0001;
         endcase
      end
      stall_age--;
      stall_pos = stall_pos + 4'd1;
      rsp_chan.ready <= stall_mask[stall_pos];
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            board.note_sample(req_chan.sample_time, req_chan.chip_select_n,
                              req_chan.clock_level, req_chan.dq_nibble);
         if (rsp_chan.valid && rsp_chan.ready)
            board.check_symbol('{kind: rsp_chan.symbol_kind, data_byte: rsp_chan.data_byte,
                                 start_time: rsp_chan.start_time,
                                 duration: rsp_chan.duration,
                                 last_of_run: rsp_chan.last_of_run});
      end
   end

   // offer one sample and hold it until taken; called at a falling edge
   task automatic send_sample(input logic [TW-1:0] t, input logic cs_n, input logic clk,
                              input logic [3:0] dq);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      now = t;
      req_chan.valid         <= 1'b1;
      req_chan.sample_time   <= t;
      req_chan.chip_select_n <= cs_n;
      req_chan.clock_level   <= clk;
      req_chan.dq_nibble     <= dq;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic step(input logic cs_n, input logic clk, input logic [3:0] dq,
                       input bit counted);
      logic [TW-1:0] t;
      case ($urandom_range(0, 63))
         0: t = TW'({$urandom, $urandom});
         1: t = now - $urandom_range(1, 5000);
         default: t = now + $urandom_range(1, 400);
      endcase
      send_sample(t, cs_n, clk, dq);
      if (counted) sent_count++;
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (board.due_symbols.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic random_packet();
      int nibbles;
      nibbles = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 9);
      // two deselected samples leave the bus deselected from any phase
      step(1'b1, 1'b0, 4'($urandom), 1'b0);
      step(1'b1, 1'b0, 4'($urandom), 1'b0);
      step(1'b0, 1'($urandom), 4'($urandom), 1'b1);
      if ($urandom_range(0, 1) == 0) step(1'b0, 1'b0, 4'($urandom), 1'b1);
      repeat (nibbles) begin
         step(1'b0, 1'b1, 4'($urandom), 1'b1);
         if ($urandom_range(0, 3) == 0) step(1'b0, 1'b1, 4'($urandom), 1'b1);
         step(1'b0, 1'b0, 4'($urandom), 1'b1);
      end
      case ($urandom_range(0, 3))
         0, 1: step(1'b1, 1'b0, 4'($urandom), 1'b1);
         2: begin
            step(1'b0, 1'b1, 4'($urandom), 1'b1);
            step(1'b1, 1'b1, 4'($urandom), 1'b1);
         end
         default: begin
            // rising edge with deselect: edge first, deselect next sample
            step(1'b1, 1'b1, 4'($urandom), 1'b1);
            step(1'b1, 1'b1, 4'($urandom), 1'b1);
         end
      endcase
   endtask

   initial begin
      board = new();
      reset = 1'b1;
      now = '0;
      req_chan.valid         = 1'b0;
      req_chan.sample_time   = '0;
      req_chan.chip_select_n = 1'b1;
      req_chan.clock_level   = 1'b0;
      req_chan.dq_nibble     = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: wrap and backward time, short bytes, both deselect kinds
      send_sample(TW'(0), 1'b0, 1'b0, 4'h0);
      send_sample(TW'(5), 1'b1, 1'b1, 4'hF);
      send_sample('1, 1'b0, 1'b0, 4'h0);
      send_sample(TW'(3), 1'b0, 1'b1, 4'hF);
      send_sample(TW'(4), 1'b0, 1'b0, 4'h0);
      send_sample(TW'(10), 1'b0, 1'b1, 4'h0);
      send_sample(TW'(11), 1'b0, 1'b0, 4'hF);
      send_sample(TW'(2), 1'b0, 1'b1, 4'hA);
      send_sample(TW'(20), 1'b1, 1'b0, 4'h0);
      send_sample(TW'(30), 1'b1, 1'b0, 4'h0);
      send_sample(TW'(40), 1'b0, 1'b0, 4'h0);
      send_sample(TW'(50), 1'b1, 1'b0, 4'h0);
      send_sample(TW'(60), 1'b0, 1'b0, 4'h0);
      send_sample(TW'(70), 1'b1, 1'b1, 4'h5);
      send_sample(TW'(80), 1'b1, 1'b1, 4'h5);
      send_sample(TW'(90), 1'b0, 1'b1, 4'h0);
      send_sample(TW'(100), 1'b0, 1'b1, 4'h0);
      send_sample(TW'(110), 1'b0, 1'b0, 4'h0);
      send_sample(TW'(120), 1'b0, 1'b1, 4'hF);
      send_sample('1, 1'b0, 1'b0, 4'h0);
      send_sample(TW'(200), 1'b0, 1'b1, 4'h5);
      send_sample(TW'(210), 1'b0, 1'b0, 4'h0);
      send_sample(TW'(220), 1'b0, 1'b1, 4'h5);
      send_sample(TW'(230), 1'b0, 1'b0, 4'h0);
      send_sample(TW'(240), 1'b1, 1'b0, 4'h0);
      wait_drained();

      while (sent_count < ITEM_TARGET) begin
         steady_sender = ($urandom_range(0, 5) == 0);
         case ($urandom_range(0, 15))
            0: repeat ($urandom_range(1, 10))
                  step(1'($urandom), 1'($urandom), 4'($urandom), 1'b1);
            1: wait_drained();
            default: random_packet();
         endcase
      end

      wait_drained();
      if (board.mismatches == 0 && board.due_symbols.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
